>>> sv/arbw_pkg.sv
// shared constants and types for the affine remap bilinear weight block
package arbw_pkg;

  // fixed point and field widths
  localparam int FRAC_W     = 16;
  localparam int ADDR_W     = 5;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 144;
  localparam int SLOT_W     = 22;
  localparam int IDX_W      = 23;
  localparam int WGT_W      = 24;

  // restoring divider depths: axis quotient bits and weight quotient bits
  localparam int AX_N  = 44;
  localparam int W_N   = 24;
  localparam int LANES = 4;

  // pipeline stage positions
  localparam int STG_C = AX_N + 2;
  localparam int STG_D = AX_N + 3;
  localparam int STG_E = AX_N + 4;
  localparam int TOTAL = AX_N + W_N + 6;

  localparam logic signed [24:0] DIV_ONE = 25'sh010000;
  localparam logic signed [17:0] WGT_ONE = 18'sh10000;
  localparam logic [10:0]        MAX_DETECTOR_SIDE = 11'd1024;
  localparam logic [WGT_W-1:0]   W_MAX = 24'h7fffff;
  localparam logic [WGT_W-1:0]   W_MIN = 24'h800000;

  // register map, word index
  typedef enum logic [2:0] {
    REG_ALPHA_ROW = 3'd0,
    REG_ALPHA_COL = 3'd1,
    REG_BETA_ROW  = 3'd2,
    REG_BETA_COL  = 3'd3,
    REG_PAD_WIDTH = 3'd4,
    REG_DET_WIDTH = 3'd5
  } reg_idx_t;

endpackage

>>> sv/affine_remap_bilinear_weights.sv
// affine remap of one padded-grid position with bilinear weights, pipelined
//
// Takes one pixel position per cycle unless stalled by the output, and returns one
// result per request, in order. The pipeline holds two restoring dividers, one
// quotient bit per stage: 44 stages for the axis mapping (pos+beta)/(1+alpha) and
// 24 stages for the four weights divided by (1+alpha_row)(1+alpha_col). The pipeline
// advances whenever the output register is empty or being taken. The user must
// write the registers only while the block is idle; the block does not enforce
// this. Derived divisors follow a write through d_row/d_col, norm and udn.
module affine_remap_bilinear_weights
  import arbw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // padded_row [10:0], padded_col [21:11], zero [23:22]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // table_slot [21:0], source_index [44:22], weight_here [68:45],
  // weight_next_row [92:69], weight_next_col [116:93],
  // weight_diagonal [140:117], zero [143:141]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // divide_fault [0]
  output logic [0:0]            m_tuser
);

  // configuration registers
  logic [23:0] alpha_row, alpha_col;
  logic [27:0] beta_row, beta_col;
  logic [8:0]  pad_width;
  logic [10:0] detector_width;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_row      <= '0;
      alpha_col      <= '0;
      beta_row       <= '0;
      beta_col       <= '0;
      pad_width      <= '0;
      detector_width <= 11'd1024;
    end else if (cfg_wr) begin
      case (paddr[ADDR_W-1:2])
        REG_ALPHA_ROW: alpha_row      <= pwdata[23:0];
        REG_ALPHA_COL: alpha_col      <= pwdata[23:0];
        REG_BETA_ROW:  beta_row       <= pwdata[27:0];
        REG_BETA_COL:  beta_col       <= pwdata[27:0];
        REG_PAD_WIDTH: pad_width      <= pwdata[8:0];
        REG_DET_WIDTH: detector_width <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_ALPHA_ROW: prdata = {8'b0, alpha_row};
      REG_ALPHA_COL: prdata = {8'b0, alpha_col};
      REG_BETA_ROW:  prdata = {4'b0, beta_row};
      REG_BETA_COL:  prdata = {4'b0, beta_col};
      REG_PAD_WIDTH: prdata = {23'b0, pad_width};
      REG_DET_WIDTH: prdata = {21'b0, detector_width};
      default:       prdata = '0;
    endcase
  end

  // divisors derived from the registers
  logic signed [24:0] d_row, d_col;
  logic signed [49:0] norm;
  logic [23:0]        udr, udc;
  logic [47:0]        udn;
  logic               sgr, sgc, norm_neg, fault;
  logic [24:0]        d_row_abs, d_col_abs;
  logic [49:0]        norm_abs;

  assign d_row_abs = d_row[24] ? 25'(-d_row) : 25'(d_row);
  assign d_col_abs = d_col[24] ? 25'(-d_col) : 25'(d_col);
  assign norm_abs  = norm[49] ? 50'(-norm) : 50'(norm);

  always_ff @(posedge clk) begin
    d_row    <= $signed({alpha_row[23], alpha_row}) + DIV_ONE;
    d_col    <= $signed({alpha_col[23], alpha_col}) + DIV_ONE;
    udr      <= d_row_abs[23:0];
    udc      <= d_col_abs[23:0];
    sgr      <= d_row[24];
    sgc      <= d_col[24];
    fault    <= (d_row == '0) || (d_col == '0);
    norm     <= d_row * d_col;
    udn      <= norm_abs[47:0];
    norm_neg <= norm[49];
  end

  // pipeline control
  logic [TOTAL-1:0] vld;
  logic             adv;

  assign adv      = ~vld[TOTAL-1] | m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[TOTAL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TOTAL-2:0], s_tvalid};
    end
  end

  // stage a: unpad, add offset, table slot
  logic [10:0]        prow, pcol;
  logic signed [11:0] pos_r, pos_c;
  logic [11:0]        stride;
  logic [22:0]        slot_full;
  logic signed [28:0] num_r, num_c;
  logic [SLOT_W-1:0]  slot_pipe [TOTAL-1];

  assign prow      = s_tdata[10:0];
  assign pcol      = s_tdata[21:11];
  assign pos_r     = $signed({1'b0, prow}) - $signed({3'b0, pad_width});
  assign pos_c     = $signed({1'b0, pcol}) - $signed({3'b0, pad_width});
  assign stride    = {1'b0, detector_width} + {2'b0, pad_width, 1'b0};
  assign slot_full = 23'(prow) * 23'(stride) + 23'(pcol);

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r <= $signed({pos_r[11], pos_r, 16'b0}) + $signed({beta_row[27], beta_row});
      num_c <= $signed({pos_c[11], pos_c, 16'b0}) + $signed({beta_col[27], beta_col});
      slot_pipe[0] <= slot_full[SLOT_W-1:0];
      for (int i = 1; i < TOTAL - 1; i++) begin
        slot_pipe[i] <= slot_pipe[i-1];
      end
    end
  end

  // stage b: magnitudes into the axis dividers
  logic [23:0]     ax_rem_r [AX_N+1];
  logic [23:0]     ax_rem_c [AX_N+1];
  logic [AX_N-1:0] ax_nq_r  [AX_N+1];
  logic [AX_N-1:0] ax_nq_c  [AX_N+1];
  logic            ax_sg_r  [AX_N+1];
  logic            ax_sg_c  [AX_N+1];
  logic [28:0]     mag_r, mag_c;

  assign mag_r = num_r[28] ? 29'(-num_r) : 29'(num_r);
  assign mag_c = num_c[28] ? 29'(-num_c) : 29'(num_c);

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_rem_r[0] <= '0;
      ax_rem_c[0] <= '0;
      ax_nq_r[0]  <= {mag_r[27:0], 16'b0};
      ax_nq_c[0]  <= {mag_c[27:0], 16'b0};
      ax_sg_r[0]  <= num_r[28] ^ sgr;
      ax_sg_c[0]  <= num_c[28] ^ sgc;
    end
  end

  // axis dividers, one quotient bit per stage
  for (genvar k = 1; k <= AX_N; k++) begin : g_ax
    logic [24:0] t_r, t_c, df_r, df_c;
    logic        ge_r, ge_c;

    assign t_r  = {ax_rem_r[k-1], ax_nq_r[k-1][AX_N-1]};
    assign t_c  = {ax_rem_c[k-1], ax_nq_c[k-1][AX_N-1]};
    assign ge_r = t_r >= {1'b0, udr};
    assign ge_c = t_c >= {1'b0, udc};
    assign df_r = t_r - {1'b0, udr};
    assign df_c = t_c - {1'b0, udc};

    always_ff @(posedge clk) begin
      if (adv) begin
        ax_rem_r[k] <= ge_r ? df_r[23:0] : t_r[23:0];
        ax_rem_c[k] <= ge_c ? df_c[23:0] : t_c[23:0];
        ax_nq_r[k]  <= {ax_nq_r[k-1][AX_N-2:0], ge_r};
        ax_nq_c[k]  <= {ax_nq_c[k-1][AX_N-2:0], ge_c};
        ax_sg_r[k]  <= ax_sg_r[k-1];
        ax_sg_c[k]  <= ax_sg_c[k-1];
      end
    end
  end

  // stage c: signed integer part (low bits) and fraction
  logic [IDX_W-1:0]   irm, icm;
  logic [16:0]        frm, fcm;
  logic [IDX_W-1:0]   ir, ic;
  logic signed [16:0] fr, fc;

  assign irm = ax_nq_r[AX_N][38:16];
  assign icm = ax_nq_c[AX_N][38:16];
  assign frm = {1'b0, ax_nq_r[AX_N][15:0]};
  assign fcm = {1'b0, ax_nq_c[AX_N][15:0]};

  always_ff @(posedge clk) begin
    if (adv) begin
      ir <= ax_sg_r[AX_N] ? (~irm + 23'd1) : irm;
      ic <= ax_sg_c[AX_N] ? (~icm + 23'd1) : icm;
      fr <= ax_sg_r[AX_N] ? $signed(~frm + 17'd1) : $signed(frm);
      fc <= ax_sg_c[AX_N] ? $signed(~fcm + 17'd1) : $signed(fcm);
    end
  end

  // stage d: source index and weight numerators
  logic [10:0]        dw_eff;
  logic [IDX_W-1:0]   idx_mul;
  logic signed [17:0] fr18, fc18, omr, omc;
  logic signed [35:0] prod [LANES];
  logic [IDX_W-1:0]   idx_pipe [W_N+2];

  assign dw_eff  = (detector_width > MAX_DETECTOR_SIDE) ? MAX_DETECTOR_SIDE : detector_width;
  assign idx_mul = IDX_W'(ir * {12'b0, dw_eff});
  assign fr18    = {fr[16], fr};
  assign fc18    = {fc[16], fc};
  assign omr     = WGT_ONE - fr18;
  assign omc     = WGT_ONE - fc18;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod[0] <= omr * omc;
      prod[1] <= fr18 * omc;
      prod[2] <= omr * fc18;
      prod[3] <= fr18 * fc18;
      idx_pipe[0] <= idx_mul + ic;
      for (int i = 1; i < W_N + 2; i++) begin
        idx_pipe[i] <= idx_pipe[i-1];
      end
    end
  end

  // stage e and weight dividers, one lane per weight
  logic [47:0]    wrem [LANES][W_N+1];
  logic [W_N-1:0] wnq  [LANES][W_N+1];
  logic           wsat [LANES][W_N+1];
  logic           wneg [LANES][W_N+1];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [35:0] pm;
    logic        sat;

    // saturate when the quotient would reach 2^24
    assign pm  = prod[l][35] ? 36'(-prod[l]) : 36'(prod[l]);
    assign sat = {21'b0, pm[34:0]} >= {udn, 8'b0};

    always_ff @(posedge clk) begin
      if (adv) begin
        wrem[l][0] <= sat ? 48'd0 : {21'b0, pm[34:8]};
        wnq[l][0]  <= {pm[7:0], 16'b0};
        wsat[l][0] <= sat;
        wneg[l][0] <= prod[l][35] ^ norm_neg;
      end
    end

    for (genvar k = 1; k <= W_N; k++) begin : g_wst
      logic [48:0] t, df;
      logic        ge;

      assign t  = {wrem[l][k-1], wnq[l][k-1][W_N-1]};
      assign ge = t >= {1'b0, udn};
      assign df = t - {1'b0, udn};

      always_ff @(posedge clk) begin
        if (adv) begin
          wrem[l][k] <= ge ? df[47:0] : t[47:0];
          wnq[l][k]  <= {wnq[l][k-1][W_N-2:0], ge};
          wsat[l][k] <= wsat[l][k-1];
          wneg[l][k] <= wneg[l][k-1];
        end
      end
    end
  end

  // output stage: sign, saturation, fault masking
  logic [WGT_W-1:0] wval [LANES];
  logic [WGT_W-1:0] out_w [LANES];
  logic [SLOT_W-1:0] out_slot;
  logic [IDX_W-1:0]  out_idx;
  logic              out_fault;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (wsat[l][W_N]) begin
        wval[l] = wneg[l][W_N] ? W_MIN : W_MAX;
      end else if (wneg[l][W_N]) begin
        wval[l] = wnq[l][W_N][W_N-1] ? W_MIN : (~wnq[l][W_N] + 24'd1);
      end else begin
        wval[l] = wnq[l][W_N][W_N-1] ? W_MAX : wnq[l][W_N];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_slot  <= slot_pipe[TOTAL-2];
      out_idx   <= fault ? '0 : idx_pipe[W_N+1];
      out_fault <= fault;
      for (int l = 0; l < LANES; l++) begin
        out_w[l] <= fault ? '0 : wval[l];
      end
    end
  end

  assign m_tdata = {3'b0, out_w[3], out_w[2], out_w[1], out_w[0], out_idx, out_slot};
  assign m_tuser = out_fault;

  // checks
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> vld == $past(vld))
    else $error("pipeline moved while stalled");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[140:22] == '0)
    else $error("fault result carries nonzero index or weights");

  a_ax_rem: assert property (@(posedge clk) disable iff (rst)
    vld[STG_C-1] && !fault |-> ax_rem_r[AX_N] < udr && ax_rem_c[AX_N] < udc)
    else $error("axis divider remainder not below divisor");

  a_w_rem: assert property (@(posedge clk) disable iff (rst)
    vld[TOTAL-2] && !fault |-> wrem[0][W_N] < udn && wrem[3][W_N] < udn)
    else $error("weight divider remainder not below divisor");

endmodule

>>> dv/affine_remap_bilinear_weights_tb.sv
// self-checking testbench for the affine remap bilinear weight block
`timescale 1ns / 1ps

module affine_remap_bilinear_weights_tb;
  import arbw_pkg::*;

  // index past the end of the register map, writes are dropped
  localparam logic [2:0] REG_UNMAPPED = 3'd6;
  localparam int RAND_PHASES = 11;
  localparam int PHASE_ITEMS = 150;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [IDX_W-1:0]  idx;
    logic [WGT_W-1:0]  w_here;
    logic [WGT_W-1:0]  w_row;
    logic [WGT_W-1:0]  w_col;
    logic [WGT_W-1:0]  w_diag;
    logic              fault;
  } remap_t;

  typedef struct {
    int          setting;
    logic [10:0] row;
    logic [10:0] col;
    bit          typed;
    remap_t      exp;
  } vec_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0]            m_tuser;

  // register copies used for prediction
  logic [23:0] alpha_row_q;
  logic [23:0] alpha_col_q;
  logic [27:0] beta_row_q;
  logic [27:0] beta_col_q;
  logic [8:0]  pad_q;
  logic [10:0] det_q;

  remap_t pending_q[$];
  int     errors;
  bit     quiet;
  bit     hold_req;

  // directed settings: alpha_row, alpha_col, beta_row, beta_col, pad, width
  logic [31:0] dir_cfg [6][6] = '{
    '{32'h0, 32'h0, 32'h0, 32'h0, 32'd0, 32'd1024},
    '{32'hffff0000, 32'h0, 32'h0, 32'h0, 32'd0, 32'd1024},
    '{32'h0, 32'hffff0000, 32'h0, 32'h0, 32'd0, 32'd1024},
    '{32'h7fffff, 32'h800000, 32'h7ffffff, 32'h8000000, 32'd511, 32'd2047},
    '{32'hffff0001, 32'hffff0001, 32'h8000, 32'hffff8000, 32'd100, 32'd1},
    '{32'h4000, 32'hffffc000, 32'h12345, 32'hfff6789a, 32'd0, 32'd0}
  };

  vec_t dir_tbl [] = '{
    '{0, 11'd0, 11'd0, 1, '{22'd0, 23'd0, 24'h10000, 24'h0, 24'h0, 24'h0, 1'b0}},
    '{0, 11'd2047, 11'd2047, 1,
      '{22'd2098175, 23'd2098175, 24'h10000, 24'h0, 24'h0, 24'h0, 1'b0}},
    '{0, 11'd2047, 11'd0, 1,
      '{22'd2096128, 23'd2096128, 24'h10000, 24'h0, 24'h0, 24'h0, 1'b0}},
    '{0, 11'd0, 11'd2047, 1,
      '{22'd2047, 23'd2047, 24'h10000, 24'h0, 24'h0, 24'h0, 1'b0}},
    '{0, 11'h555, 11'h2aa, 0, '0},
    '{1, 11'd5, 11'd7, 1, '{22'd5127, 23'd0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b1}},
    '{1, 11'd2047, 11'd2047, 1,
      '{22'd2098175, 23'd0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b1}},
    '{2, 11'd3, 11'd3, 1, '{22'd3075, 23'd0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b1}},
    '{3, 11'd0, 11'd0, 0, '0},
    '{3, 11'd2047, 11'd2047, 0, '0},
    '{3, 11'd511, 11'd511, 0, '0},
    '{3, 11'd1000, 11'd3, 0, '0},
    '{4, 11'd0, 11'd0, 0, '0},
    '{4, 11'd50, 11'd150, 0, '0},
    '{4, 11'd200, 11'd60, 0, '0},
    '{4, 11'd100, 11'd100, 0, '0},
    '{5, 11'd10, 11'd20, 0, '0},
    '{5, 11'd2047, 11'd1, 0, '0},
    '{5, 11'd1, 11'd2047, 0, '0},
    '{5, 11'h2aa, 11'h555, 0, '0}
  };

  affine_remap_bilinear_weights dut (.*);

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // weight quotient in Q.16, truncated toward zero and saturated
  function automatic logic [WGT_W-1:0] weight_quotient(longint num, longint den);
    bit neg;
    longint unsigned un, ud, q0, rem, res;
    int k;
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q0 = un / ud;
    rem = un % ud;
    if (q0 > 128) begin
      res = 64'd1 << 24;
    end else begin
      res = q0;
      for (k = 0; k < FRAC_W; k++) begin
        rem = rem << 1;
        res = res << 1;
        if (rem >= ud) begin
          rem = rem - ud;
          res = res | 64'd1;
        end
      end
    end
    if (neg) begin
      if (res >= (64'd1 << 23)) return W_MIN;
      return WGT_W'(-longint'(res));
    end
    if (res > 64'd8388607) return W_MAX;
    return WGT_W'(res);
  endfunction

  // expected remap of one padded position under the current registers
  function automatic remap_t remap_predict(logic [10:0] row, logic [10:0] col);
    longint one, d_row, d_col, q, ir, fr, ic, fc, norm, dw;
    remap_t o;
    one = longint'(1) << FRAC_W;
    o = '0;
    o.slot = SLOT_W'(longint'(row) * (longint'(det_q) + 2 * longint'(pad_q))
                     + longint'(col));
    d_row = one + longint'($signed(alpha_row_q));
    d_col = one + longint'($signed(alpha_col_q));
    if (d_row == 0 || d_col == 0) begin
      o.fault = 1'b1;
      return o;
    end
    q = (((longint'(row) - longint'(pad_q)) * one + longint'($signed(beta_row_q)))
         * one) / d_row;
    ir = q / one;
    fr = q % one;
    q = (((longint'(col) - longint'(pad_q)) * one + longint'($signed(beta_col_q)))
         * one) / d_col;
    ic = q / one;
    fc = q % one;
    dw = (det_q > MAX_DETECTOR_SIDE) ? longint'(MAX_DETECTOR_SIDE) : longint'(det_q);
    o.idx = IDX_W'(ir * dw + ic);
    norm = d_row * d_col;
    o.w_here = weight_quotient((one - fr) * (one - fc), norm);
    o.w_row  = weight_quotient(fr * (one - fc), norm);
    o.w_col  = weight_quotient((one - fr) * fc, norm);
    o.w_diag = weight_quotient(fr * fc, norm);
    return o;
  endfunction

  task automatic flag_error(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic compare_field(string name, longint unsigned e, longint unsigned a);
    if (e != a) flag_error($sformatf("%s expected %h actual %h", name, e, a));
  endtask

  // register write, setup then access
  task automatic reg_write(logic [2:0] ridx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {ridx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (ridx)
      REG_ALPHA_ROW: alpha_row_q = value[23:0];
      REG_ALPHA_COL: alpha_col_q = value[23:0];
      REG_BETA_ROW:  beta_row_q = value[27:0];
      REG_BETA_COL:  beta_col_q = value[27:0];
      REG_PAD_WIDTH: pad_q = value[8:0];
      REG_DET_WIDTH: det_q = value[10:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(logic [31:0] v [6]);
    reg_write(REG_ALPHA_ROW, v[0]);
    reg_write(REG_ALPHA_COL, v[1]);
    reg_write(REG_BETA_ROW, v[2]);
    reg_write(REG_BETA_COL, v[3]);
    reg_write(REG_PAD_WIDTH, v[4]);
    reg_write(REG_DET_WIDTH, v[5]);
    reg_write(REG_UNMAPPED, $urandom);
    // wait for the derived divisors to settle
    repeat (4) @(posedge clk);
  endtask

  // wait until every expected result is back
  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // offer one request and hold it until accepted
  task automatic send_request(logic [10:0] row, logic [10:0] col, bit typed,
                              remap_t exp);
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, col, row};
    do @(posedge clk); while (!s_tready);
    pending_q.push_back(typed ? exp : remap_predict(row, col));
    if (!quiet && $urandom_range(99) < 13) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_alpha();
    case ($urandom_range(9))
      0: return 32'hffff0000;
      1: return $urandom;
      2: return 32'h7fffff;
      3: return 32'h800000;
      default: return $urandom_range(65535) - 32768;
    endcase
  endfunction

  function automatic logic [31:0] pick_beta();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h0;
      default: return $urandom_range(2 * 300 * 65536) - 300 * 65536;
    endcase
  endfunction

  // result checking
  always @(posedge clk) begin
    remap_t got, exp;
    if (!rst && m_tvalid && m_tready) begin
      got.slot = m_tdata[21:0];
      got.idx = m_tdata[44:22];
      got.w_here = m_tdata[68:45];
      got.w_row = m_tdata[92:69];
      got.w_col = m_tdata[116:93];
      got.w_diag = m_tdata[140:117];
      got.fault = m_tuser[0];
      if (pending_q.size() == 0) begin
        flag_error($sformatf("unexpected result %h", m_tdata));
      end else begin
        exp = pending_q.pop_front();
        compare_field("table_slot", exp.slot, got.slot);
        compare_field("source_index", exp.idx, got.idx);
        compare_field("weight_here", exp.w_here, got.w_here);
        compare_field("weight_next_row", exp.w_row, got.w_row);
        compare_field("weight_next_col", exp.w_col, got.w_col);
        compare_field("weight_diagonal", exp.w_diag, got.w_diag);
        compare_field("divide_fault", exp.fault, got.fault);
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 24);
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // stimulus
  initial begin
    logic [31:0] v [6];
    int cur;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    errors = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    alpha_row_q = '0;
    alpha_col_q = '0;
    beta_row_q = '0;
    beta_col_q = '0;
    pad_q = '0;
    det_q = 11'd1024;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, setting zero is the reset state
    cur = 0;
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].setting != cur) begin
        s_tvalid <= 1'b0;
        drain();
        cur = dir_tbl[i].setting;
        load_setting(dir_cfg[cur]);
      end
      send_request(dir_tbl[i].row, dir_tbl[i].col, dir_tbl[i].typed, dir_tbl[i].exp);
    end

    // random phases, each under a fresh register setting
    for (int p = 0; p < RAND_PHASES; p++) begin
      s_tvalid <= 1'b0;
      drain();
      v[0] = pick_alpha();
      v[1] = pick_alpha();
      v[2] = pick_beta();
      v[3] = pick_beta();
      v[4] = ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(40);
      v[5] = ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(1, 1024);
      load_setting(v);
      quiet = (p == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == 20) hold_req = 1'b1;
        send_request($urandom_range(2047), $urandom_range(2047), 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;
    quiet = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (errors == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
